FILE: design/i2c_pkg.sv
`default_nettype none
package i2c_pkg;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_INPUT_DIMS  = 3'd0,
		REG_OUTPUT_DIMS = 3'd1,
		REG_STRIDES     = 3'd2,
		REG_DILATIONS   = 3'd3,
		REG_PADS        = 3'd4
	} reg_idx_t;

	// one segment request, as handed from front to back
	typedef struct packed {
		logic [11:0] channel;
		logic [7:0]  tap_d;
		logic [7:0]  tap_h;
		logic [7:0]  tap_w;
		logic [23:0] col;
		logic [6:0]  count;
	} seg_t;
endpackage
`default_nettype wire

FILE: design/i2c_front.sv
`default_nettype none
// Accepts requests, drops zero-count ones, saturates the count and queues them.
module i2c_front #(
	parameter int SEG_MAX = 48,
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic [11:0]    channel,
	input  wire logic [7:0]     tap_d,
	input  wire logic [7:0]     tap_h,
	input  wire logic [7:0]     tap_w,
	input  wire logic [23:0]    first_col,
	input  wire logic [5:0]     count,
	output logic                seg_valid,
	input  wire logic           seg_take,
	output i2c_pkg::seg_t       seg
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	i2c_pkg::seg_t mem_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          wr;
	logic [6:0]    n;

	assign full = (cnt_q == (PW+1)'(DEPTH));
	assign seg_valid = (cnt_q != '0);
	assign seg = mem_q[rp_q];
	assign wr = push && !full && (count != 6'd0);
	assign n = ({1'b0, count} > 7'(SEG_MAX)) ? 7'(SEG_MAX) : {1'b0, count};

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= '{channel, tap_d, tap_h, tap_w, first_col, n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (seg_take) rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(wr) - (PW+1)'(seg_take);
		end
	end
endmodule
`default_nettype wire

FILE: design/i2c_back.sv
`default_nettype none
// Splits the start column by restoring division, then walks columns with counters.
// Per column: stage 1 forms coordinates, stage 2 bounds and first products,
// stage 3/4 build the offset in two multiply steps.
module i2c_back #(
	parameter int DIM_BITS = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          seg_valid,
	output logic               seg_take,
	input  wire i2c_pkg::seg_t seg,
	input  wire logic [47:0]   input_dims,
	input  wire logic [31:0]   output_dims,
	input  wire logic [23:0]   strides,
	input  wire logic [23:0]   dilations,
	input  wire logic [23:0]   pads,
	output logic               res_valid,
	input  wire logic          res_ready,
	output logic [31:0]        res_offset,
	output logic               res_pad,
	output logic               res_last
);
	localparam int QW = 24;
	typedef enum logic [3:0] {
		IDLE = 4'b0001, DIV1 = 4'b0010, DIV2 = 4'b0100, RUN = 4'b1000
	} st_t;
	st_t st_q;
	logic [4:0]  bit_q;
	logic [23:0] rem_q, quo_q;
	logic [DIM_BITS-1:0] ow_q, oh_q;
	// one bit above the column width: the walk can run past the last 24-bit column
	logic [24:0] od_q;
	logic [6:0]  left_q;
	i2c_pkg::seg_t s_q;
	logic zero_q;

	logic [DIM_BITS-1:0] idd, ihd, iwd, ohd, owd;
	assign idd = input_dims[32 +: DIM_BITS];
	assign ihd = input_dims[16 +: DIM_BITS];
	assign iwd = input_dims[0 +: DIM_BITS];
	assign ohd = output_dims[16 +: DIM_BITS];
	assign owd = output_dims[0 +: DIM_BITS];

	// output pipe: 4 stages, plus a 4-entry result queue; issue only with room
	logic v1, v2, v3, v4;
	logic [2:0] qcnt_q;
	logic [2:0] inflight;
	logic issue;
	assign inflight = 3'(v1) + 3'(v2) + 3'(v3) + 3'(v4);
	assign issue = (st_q == RUN) && ({1'b0, qcnt_q} + {1'b0, inflight} < 4'd4);
	assign seg_take = (st_q == IDLE) && seg_valid;

	// restoring division step over 24 bits
	logic [23:0] dv;
	logic [24:0] trial;
	logic [23:0] rnext;
	assign dv = (st_q == DIV1) ? 24'(owd) : 24'(ohd);
	assign rnext = {rem_q[22:0], quo_q[23]};
	assign trial = {1'b0, rnext} - {1'b0, dv};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			left_q <= '0;
			bit_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			ow_q <= '0;
			oh_q <= '0;
			od_q <= '0;
			zero_q <= 1'b0;
			s_q <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					if (seg_valid) begin
						s_q <= seg;
						left_q <= seg.count;
						zero_q <= (ohd == '0) || (owd == '0);
						rem_q <= '0;
						quo_q <= seg.col;
						bit_q <= 5'(QW - 1);
						st_q <= ((ohd == '0) || (owd == '0)) ? RUN : DIV1;
					end
				end
				DIV1, DIV2: begin
					quo_q <= {quo_q[22:0], ~trial[24]};
					rem_q <= trial[24] ? rnext : trial[23:0];
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						if (st_q == DIV1) begin
							ow_q <= DIM_BITS'(trial[24] ? rnext : trial[23:0]);
							quo_q <= {quo_q[22:0], ~trial[24]};
							rem_q <= '0;
							bit_q <= 5'(QW - 1);
							st_q <= DIV2;
						end else begin
							oh_q <= DIM_BITS'(trial[24] ? rnext : trial[23:0]);
							od_q <= {1'b0, quo_q[22:0], ~trial[24]};
							st_q <= RUN;
						end
					end
				end
				RUN: begin
					if (issue) begin
						left_q <= left_q - 1'b1;
						if (left_q == 7'd1) st_q <= IDLE;
						if (!zero_q) begin
							if ({1'b0, ow_q} + 1'b1 == {1'b0, owd}) begin
								ow_q <= '0;
								if ({1'b0, oh_q} + 1'b1 == {1'b0, ohd}) begin
									oh_q <= '0;
									od_q <= od_q + 1'b1;
								end else begin
									oh_q <= oh_q + 1'b1;
								end
							end else begin
								ow_q <= ow_q + 1'b1;
							end
						end
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	// stage 1: raw coordinates out*stride + tap*dil
	logic [32:0] rd_s1, rh_s1, rw_s1;
	logic pz_s1, last_s1;
	logic [11:0] ch_s1;
	always_ff @(posedge clk) begin
		rd_s1 <= 33'(od_q) * 33'(strides[23:16]) + 33'(s_q.tap_d) * 33'(dilations[23:16]);
		rh_s1 <= 33'(oh_q) * 33'(strides[15:8]) + 33'(s_q.tap_h) * 33'(dilations[15:8]);
		rw_s1 <= 33'(ow_q) * 33'(strides[7:0]) + 33'(s_q.tap_w) * 33'(dilations[7:0]);
		pz_s1 <= zero_q;
		last_s1 <= (left_q == 7'd1);
		ch_s1 <= s_q.channel;
	end

	// stage 2: bounds, first product ch*ID + cd
	logic [32:0] cd, chh, cw;
	logic in_d, in_h, in_w;
	assign cd = rd_s1 - 33'(pads[23:16]);
	assign chh = rh_s1 - 33'(pads[15:8]);
	assign cw = rw_s1 - 33'(pads[7:0]);
	assign in_d = (rd_s1 >= 33'(pads[23:16])) && (cd < 33'(idd));
	assign in_h = (rh_s1 >= 33'(pads[15:8])) && (chh < 33'(ihd));
	assign in_w = (rw_s1 >= 33'(pads[7:0])) && (cw < 33'(iwd));
	logic [31:0] a_s2;
	logic [31:0] h_s2, w_s2;
	logic ins_s2, last_s2;
	always_ff @(posedge clk) begin
		a_s2 <= 32'(ch_s1) * 32'(idd) + cd[31:0];
		h_s2 <= chh[31:0];
		w_s2 <= cw[31:0];
		ins_s2 <= !pz_s1 && in_d && in_h && in_w;
		last_s2 <= last_s1;
	end

	logic [31:0] b_s3, w_s3;
	logic ins_s3, last_s3;
	always_ff @(posedge clk) begin
		b_s3 <= 32'(a_s2 * ihd) + h_s2;
		w_s3 <= w_s2;
		ins_s3 <= ins_s2;
		last_s3 <= last_s2;
	end

	logic [31:0] off_s4;
	logic ins_s4, last_s4;
	always_ff @(posedge clk) begin
		off_s4 <= 32'(b_s3 * iwd) + w_s3;
		ins_s4 <= ins_s3;
		last_s4 <= last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			v1 <= issue;
			v2 <= v1;
			v3 <= v2;
			v4 <= v3;
		end
	end

	// result queue
	logic [33:0] rq_q [4];
	logic [1:0] rwp_q, rrp_q;
	logic pop_r;
	assign res_valid = (qcnt_q != '0);
	assign pop_r = res_valid && res_ready;
	assign {res_offset, res_pad, res_last} = rq_q[rrp_q];
	always_ff @(posedge clk) begin
		if (v4) rq_q[rwp_q] <= {ins_s4 ? off_s4 : 32'd0, !ins_s4, last_s4};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rwp_q <= '0;
			rrp_q <= '0;
			qcnt_q <= '0;
		end else begin
			if (v4) rwp_q <= rwp_q + 1'b1;
			if (pop_r) rrp_q <= rrp_q + 1'b1;
			qcnt_q <= qcnt_q + 3'(v4) - 3'(pop_r);
		end
	end
endmodule
`default_nettype wire

FILE: design/im2col_address_generator.sv
// Start-up: the start column is split by two 24-step divisions, then the columns
// enter a 4-stage offset pipe; both divisions are skipped when output H or W is 0.
// Flow: issue is credited against the 4-entry result queue, so at most four results
// are in pipe and queue at once; next segment waits for the last column to issue.
// Reset: asynchronous active-low arst_n empties both queues and loads
// register defaults (strides and dilations 1, others 0).
`default_nettype none
module im2col_address_generator #(
	parameter int SEG_MAX = 48,
	parameter int DIM_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [11:0] channel,
	input  wire logic [7:0]  tap_d,
	input  wire logic [7:0]  tap_h,
	input  wire logic [7:0]  tap_w,
	input  wire logic [23:0] first_col,
	input  wire logic [5:0]  count,
	output logic             empty,
	input  wire logic        pop,
	output logic [31:0]      src_offset,
	output logic             pad_zero,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data
);
	logic [47:0] input_dims_q;
	logic [31:0] output_dims_q;
	logic [23:0] strides_q, dilations_q, pads_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_dims_q <= '0;
			output_dims_q <= '0;
			strides_q <= 24'h010101;
			dilations_q <= 24'h010101;
			pads_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				i2c_pkg::REG_INPUT_DIMS:  input_dims_q <= cfg_data;
				i2c_pkg::REG_OUTPUT_DIMS: output_dims_q <= cfg_data[31:0];
				i2c_pkg::REG_STRIDES:     strides_q <= cfg_data[23:0];
				i2c_pkg::REG_DILATIONS:   dilations_q <= cfg_data[23:0];
				i2c_pkg::REG_PADS:        pads_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic seg_valid, seg_take, res_valid;
	i2c_pkg::seg_t seg;

	i2c_front #(.SEG_MAX(SEG_MAX), .DEPTH(2)) u_front (
		.clk, .arst_n, .push, .full, .channel, .tap_d, .tap_h, .tap_w,
		.first_col, .count, .seg_valid, .seg_take, .seg
	);

	i2c_back #(.DIM_BITS(DIM_BITS)) u_back (
		.clk, .arst_n, .seg_valid, .seg_take, .seg,
		.input_dims(input_dims_q), .output_dims(output_dims_q),
		.strides(strides_q), .dilations(dilations_q), .pads(pads_q),
		.res_valid, .res_ready(pop), .res_offset(src_offset),
		.res_pad(pad_zero), .res_last(last)
	);
	assign empty = !res_valid;
endmodule
`default_nettype wire
